// File: rtl/pce_pkg.sv
// Package with the shared types and constants of the parametric curve evaluator.
`timescale 1ns / 1ps
package pce_pkg;

  // Operation codes of an input item.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  // Curve modes.
  typedef enum logic [1:0] {
    MODE_HERMITE = 2'd0,
    MODE_INTERP  = 2'd1,
    MODE_BEZ6    = 2'd2,
    MODE_BEZ3X2  = 2'd3
  } mode_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POW,
    ST_BASIS,
    ST_MULX,
    ST_MULY,
    ST_VSTEP,
    ST_ROUND
  } state_t;

  localparam int UW   = 17;   // Q1.16 parameter width
  localparam int CW   = 16;   // Q4.12 coordinate width
  localparam int PTW  = 18;   // point width including the derived point
  localparam int BW   = 24;   // basis width, signed
  localparam int MBW  = 19;   // second multiplier operand, signed
  localparam int PRW  = BW + MBW;
  localparam int ACW  = 46;   // accumulator width
  localparam int KW   = 3;    // point counter width
  localparam logic [UW-1:0] ONE_Q16 = 17'd65536;

  // Binomial coefficient for degree three or six.
  function automatic logic [4:0] binom(input logic deg6, input logic [KW-1:0] k);
    logic [4:0] c;
    c = 5'd0;
    if (deg6) begin
      case (k)
        3'd0, 3'd6: c = 5'd1;
        3'd1, 3'd5: c = 5'd6;
        3'd2, 3'd4: c = 5'd15;
        3'd3:       c = 5'd20;
        default:    c = 5'd0;
      endcase
    end else begin
      case (k)
        3'd0, 3'd3: c = 5'd1;
        3'd1, 3'd2: c = 5'd3;
        default:    c = 5'd0;
      endcase
    end
    return c;
  endfunction

endpackage

// File: rtl/pce_if.sv
// Channel interfaces of the parametric curve evaluator.
`timescale 1ns / 1ps
interface pce_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [2:0]  point_index;
  logic signed [15:0] coord_x;
  logic signed [15:0] coord_y;
  logic [16:0] param_u;
  logic        segment;
  modport source (output valid, operation, point_index, coord_x, coord_y, param_u, segment,
                  input ready);
  modport sink   (input valid, operation, point_index, coord_x, coord_y, param_u, segment,
                  output ready);
endinterface

interface pce_out_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] curve_x;
  logic signed [15:0] curve_y;
  logic        saturated;
  modport source (output valid, curve_x, curve_y, saturated, input ready);
  modport sink   (input valid, curve_x, curve_y, saturated, output ready);
endinterface

interface pce_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] curve_mode;
  modport source (output valid, curve_mode, input ready);
  modport sink   (input valid, curve_mode, output ready);
endinterface

// File: rtl/parametric_curve_evaluator.sv
// Top level of the parametric curve evaluator: point store, sequencer and shared multiplier.
`timescale 1ns / 1ps
// Usage:
// in_chan carries items. A load item (operation 0) writes one control point if its
// index is below MAX_POINTS, and gives no result. An evaluate item (operation 1)
// gives the parameter u and yields one result item on out_chan.
// cfg_chan writes curve_mode and is always ready. It is to be written only while
// idle; the user must keep to this, as the block itself does not enforce it.
// One shared 24x19 multiplier forms the powers of u (3 or 6 steps), then per control
// point the basis term, the x product, the y product and, for Bezier modes, the
// next power of 1-u, and a last step rounds and clamps.
// in_chan is ready only while the sequencer is idle, so one evaluate item is
// in flight at a time.
// The result sits in an output register; if the receiver stalls, the sequencer
// holds its final step until that register is free.
// Synchronous reset clears control points to zero, the mode to Hermite, and
// empties the output register.
module parametric_curve_evaluator #(
  parameter int MAX_POINTS = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  pce_in_if.sink        in_chan,
  pce_out_if.source     out_chan,
  pce_cfg_if.sink       cfg_chan
);

  localparam int IW = $clog2(MAX_POINTS);

  pce_pkg::state_t state_r, state_nxt;
  logic [1:0]                  mode_r;
  logic                        seg_r, seg_nxt;
  logic [pce_pkg::KW-1:0]      k_r, k_nxt, n_r, n_nxt;
  logic [pce_pkg::UW-1:0]      u_r, u_nxt, v_r, v_nxt, pw_r, pw_nxt, vp_r, vp_nxt;
  logic [pce_pkg::UW-1:0]      up_r [1:6];
  logic signed [pce_pkg::BW-1:0]  b_r, b_nxt;
  logic signed [pce_pkg::ACW-1:0] accx_r, accx_nxt, accy_r, accy_nxt;
  logic signed [pce_pkg::CW-1:0]  px_r [MAX_POINTS];
  logic signed [pce_pkg::CW-1:0]  py_r [MAX_POINTS];
  logic                        ovalid_r;
  logic signed [pce_pkg::CW-1:0]  ox_r, oy_r;
  logic                        osat_r;

  logic in_fire, is_bez, last_k, out_free;
  logic [pce_pkg::UW-1:0] u_clamp, up_k;
  logic signed [pce_pkg::BW-1:0]  mul_a, poly_b;
  logic signed [pce_pkg::MBW-1:0] mul_b;
  logic signed [pce_pkg::PRW-1:0] prod, prod_rnd;
  logic signed [pce_pkg::PTW-1:0] ptx, pty;
  logic [21:0] binomup;

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign in_chan.ready  = (state_r == pce_pkg::ST_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign is_bez   = (mode_r == pce_pkg::MODE_BEZ6) || (mode_r == pce_pkg::MODE_BEZ3X2);
  assign last_k   = (k_r == '0);
  assign out_free = !ovalid_r || out_chan.ready;
  assign u_clamp  = (in_chan.param_u > pce_pkg::ONE_Q16) ? pce_pkg::ONE_Q16 : in_chan.param_u;

  // Point read for the current index, with the mode 3 second segment remapped.
  function automatic logic signed [pce_pkg::PTW-1:0] rd_pt(
      input logic signed [pce_pkg::CW-1:0] arr [MAX_POINTS], input logic [pce_pkg::KW-1:0] idx);
    logic signed [pce_pkg::PTW-1:0] r;
    r = '0;
    if (int'(idx) < MAX_POINTS) r = pce_pkg::PTW'(arr[idx[IW-1:0]]);
    return r;
  endfunction

  always_comb begin
    logic [pce_pkg::KW-1:0] idx;
    idx = k_r;
    ptx = '0;
    pty = '0;
    if (mode_r == pce_pkg::MODE_BEZ3X2 && seg_r) begin
      if (k_r == 3'd1) begin
        ptx = (pce_pkg::PTW'(px_r[3]) <<< 1) - pce_pkg::PTW'(px_r[2]);
        pty = (pce_pkg::PTW'(py_r[3]) <<< 1) - pce_pkg::PTW'(py_r[2]);
      end else begin
        idx = (k_r == 3'd0) ? 3'd3 : k_r + 3'd2;
        ptx = rd_pt(px_r, idx);
        pty = rd_pt(py_r, idx);
      end
    end else begin
      ptx = rd_pt(px_r, idx);
      pty = rd_pt(py_r, idx);
    end
  end

  // Power of u for the current index and its weighted binomial.
  assign up_k    = (k_r == '0) ? pce_pkg::ONE_Q16 : up_r[k_r];
  assign binomup = 22'(pce_pkg::binom(mode_r == pce_pkg::MODE_BEZ6, k_r)) * 22'(up_k);

  // Polynomial basis for Hermite and interpolating modes.
  always_comb begin
    logic signed [pce_pkg::BW-1:0] a1, a2, a3;
    a1 = pce_pkg::BW'(up_r[1]);
    a2 = pce_pkg::BW'(up_r[2]);
    a3 = pce_pkg::BW'(up_r[3]);
    poly_b = '0;
    if (mode_r == pce_pkg::MODE_HERMITE) begin
      case (k_r)
        3'd0:    poly_b = pce_pkg::BW'(2 * a3 - 3 * a2 + pce_pkg::BW'(pce_pkg::ONE_Q16));
        3'd1:    poly_b = pce_pkg::BW'(3 * a2 - 2 * a3);
        3'd2:    poly_b = pce_pkg::BW'(a3 - 2 * a2 + a1);
        3'd3:    poly_b = a3 - a2;
        default: poly_b = '0;
      endcase
    end else begin
      case (k_r)
        3'd0:    poly_b = pce_pkg::BW'(18 * a2 - 9 * a3 - 11 * a1 + pce_pkg::BW'(2 * 65536));
        3'd1:    poly_b = pce_pkg::BW'(27 * a3 - 45 * a2 + 18 * a1);
        3'd2:    poly_b = pce_pkg::BW'(36 * a2 - 27 * a3 - 9 * a1);
        3'd3:    poly_b = pce_pkg::BW'(9 * a3 - 9 * a2 + 2 * a1);
        default: poly_b = '0;
      endcase
    end
  end

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      pce_pkg::ST_POW: begin
        mul_a = pce_pkg::BW'(pw_r);
        mul_b = pce_pkg::MBW'(u_r);
      end
      pce_pkg::ST_BASIS: begin
        mul_a = pce_pkg::BW'(binomup);
        mul_b = pce_pkg::MBW'(vp_r);
      end
      pce_pkg::ST_MULX: begin
        mul_a = b_r;
        mul_b = pce_pkg::MBW'(ptx);
      end
      pce_pkg::ST_MULY: begin
        mul_a = b_r;
        mul_b = pce_pkg::MBW'(pty);
      end
      pce_pkg::ST_VSTEP: begin
        mul_a = pce_pkg::BW'(vp_r);
        mul_b = pce_pkg::MBW'(v_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod     = pce_pkg::PRW'(mul_a) * pce_pkg::PRW'(mul_b);
  assign prod_rnd = (prod + pce_pkg::PRW'(32768)) >>> 16;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pce_pkg::ST_IDLE:  if (in_fire && in_chan.operation == pce_pkg::OP_EVAL) begin
        state_nxt = pce_pkg::ST_POW;
      end
      pce_pkg::ST_POW:   if (k_r == n_r) state_nxt = pce_pkg::ST_BASIS;
      pce_pkg::ST_BASIS: state_nxt = pce_pkg::ST_MULX;
      pce_pkg::ST_MULX:  state_nxt = pce_pkg::ST_MULY;
      pce_pkg::ST_MULY: begin
        if (is_bez)      state_nxt = pce_pkg::ST_VSTEP;
        else if (last_k) state_nxt = pce_pkg::ST_ROUND;
        else             state_nxt = pce_pkg::ST_BASIS;
      end
      pce_pkg::ST_VSTEP: state_nxt = last_k ? pce_pkg::ST_ROUND : pce_pkg::ST_BASIS;
      pce_pkg::ST_ROUND: if (out_free) state_nxt = pce_pkg::ST_IDLE;
      default:           state_nxt = pce_pkg::ST_IDLE;
    endcase
  end

  // Datapath next values.
  always_comb begin
    seg_nxt  = seg_r;
    k_nxt    = k_r;
    n_nxt    = n_r;
    u_nxt    = u_r;
    v_nxt    = v_r;
    pw_nxt   = pw_r;
    vp_nxt   = vp_r;
    b_nxt    = b_r;
    accx_nxt = accx_r;
    accy_nxt = accy_r;
    case (state_r)
      pce_pkg::ST_IDLE: begin
        seg_nxt  = in_chan.segment;
        u_nxt    = u_clamp;
        v_nxt    = pce_pkg::ONE_Q16 - u_clamp;
        pw_nxt   = pce_pkg::ONE_Q16;
        vp_nxt   = pce_pkg::ONE_Q16;
        accx_nxt = '0;
        accy_nxt = '0;
        k_nxt    = 3'd1;
        n_nxt    = (mode_r == pce_pkg::MODE_BEZ6) ? 3'd6 : 3'd3;
      end
      pce_pkg::ST_POW: begin
        pw_nxt = prod_rnd[pce_pkg::UW-1:0];
        k_nxt  = (k_r == n_r) ? n_r : k_r + 3'd1;
      end
      pce_pkg::ST_BASIS: b_nxt = is_bez ? prod_rnd[pce_pkg::BW-1:0] : poly_b;
      pce_pkg::ST_MULX:  accx_nxt = accx_r + pce_pkg::ACW'(prod);
      pce_pkg::ST_MULY: begin
        accy_nxt = accy_r + pce_pkg::ACW'(prod);
        if (!is_bez && !last_k) k_nxt = k_r - 3'd1;
      end
      pce_pkg::ST_VSTEP: begin
        vp_nxt = prod_rnd[pce_pkg::UW-1:0];
        if (!last_k) k_nxt = k_r - 3'd1;
      end
      default: ;
    endcase
  end

  // Final rounding to Q12 and clamping.
  function automatic logic signed [pce_pkg::CW:0] finish(
      input logic signed [pce_pkg::ACW-1:0] acc, input logic sh17);
    logic signed [pce_pkg::ACW-1:0] t;
    logic signed [pce_pkg::CW-1:0] r;
    logic s;
    t = sh17 ? (acc + pce_pkg::ACW'(65536)) >>> 17 : (acc + pce_pkg::ACW'(32768)) >>> 16;
    s = 1'b0;
    r = t[pce_pkg::CW-1:0];
    if (t > pce_pkg::ACW'(32767)) begin
      r = 16'sh7fff;
      s = 1'b1;
    end else if (t < -pce_pkg::ACW'(32768)) begin
      r = 16'sh8000;
      s = 1'b1;
    end
    return {s, r};
  endfunction

  // Registers.
  always_ff @(posedge clk) begin
    logic signed [pce_pkg::CW:0] fx, fy;
    fx = finish(accx_r, mode_r == pce_pkg::MODE_INTERP);
    fy = finish(accy_r, mode_r == pce_pkg::MODE_INTERP);
    if (!rst_n) begin
      state_r  <= pce_pkg::ST_IDLE;
      mode_r   <= pce_pkg::MODE_HERMITE;
      ovalid_r <= 1'b0;
      for (int i = 0; i < MAX_POINTS; i++) begin
        px_r[i] <= '0;
        py_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_chan.valid && cfg_chan.ready) mode_r <= cfg_chan.curve_mode;
      if (in_fire && in_chan.operation == pce_pkg::OP_LOAD &&
          int'(in_chan.point_index) < MAX_POINTS) begin
        px_r[in_chan.point_index[IW-1:0]] <= in_chan.coord_x;
        py_r[in_chan.point_index[IW-1:0]] <= in_chan.coord_y;
      end
      if (state_r == pce_pkg::ST_ROUND && out_free) begin
        ovalid_r <= 1'b1;
      end else if (out_chan.ready) begin
        ovalid_r <= 1'b0;
      end
    end
    if (state_r == pce_pkg::ST_ROUND && out_free) begin
      ox_r   <= fx[pce_pkg::CW-1:0];
      oy_r   <= fy[pce_pkg::CW-1:0];
      osat_r <= fx[pce_pkg::CW] | fy[pce_pkg::CW];
    end
    if (state_r == pce_pkg::ST_POW) up_r[k_r] <= prod_rnd[pce_pkg::UW-1:0];
    seg_r  <= seg_nxt;
    k_r    <= k_nxt;
    n_r    <= n_nxt;
    u_r    <= u_nxt;
    v_r    <= v_nxt;
    pw_r   <= pw_nxt;
    vp_r   <= vp_nxt;
    b_r    <= b_nxt;
    accx_r <= accx_nxt;
    accy_r <= accy_nxt;
  end

  assign out_chan.valid     = ovalid_r;
  assign out_chan.curve_x   = ox_r;
  assign out_chan.curve_y   = oy_r;
  assign out_chan.saturated = osat_r;

endmodule

// File: sim/parametric_curve_evaluator_tb.sv
// Self-checking testbench of the parametric curve evaluator with a predictor of curve points.
`timescale 1ns / 1ps
module parametric_curve_evaluator_tb;

  localparam int NUM_POINTS = 7;
  localparam int RANDOM_ITEMS = 1250;

  typedef struct packed {
    logic        operation;
    logic [2:0]  point_index;
    logic [15:0] coord_x;
    logic [15:0] coord_y;
    logic [16:0] param_u;
    logic        segment;
  } curve_item_t;

  typedef struct packed {
    logic [15:0] curve_x;
    logic [15:0] curve_y;
    logic        saturated;
  } curve_point_t;

  logic clk;
  logic rst_n;

  pce_in_if  in_chan ();
  pce_out_if out_chan ();
  pce_cfg_if cfg_chan ();

  parametric_curve_evaluator #(.MAX_POINTS(NUM_POINTS)) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  // Predictor state: control points and the curve mode.
  longint ctrl_x [NUM_POINTS];
  longint ctrl_y [NUM_POINTS];
  pce_pkg::mode_t model_mode;

  curve_item_t  pending_items [$];
  curve_point_t expected_points [$];

  int mismatch_count;
  int results_seen;
  int evals_sent;
  int mode_evals [4];
  int sat_seen;
  bit hold_off;
  bit stim_done;
  bit in_accepted;

  // Q16 product rounded to nearest.
  function automatic longint mul_q16(longint a, longint b);
    return (a * b + 32768) >>> 16;
  endfunction

  // Arithmetic shift with rounding half up; >>> floors for signed longint.
  function automatic longint round_q(longint acc, int sh);
    return (acc + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint clamp_coord(longint v, ref bit sat);
    if (v > 32767) begin
      sat = 1'b1;
      return 32767;
    end
    if (v < -32768) begin
      sat = 1'b1;
      return -32768;
    end
    return v;
  endfunction

  // Computes the expected curve point of one evaluate item.
  function automatic curve_point_t predict_point(curve_item_t it);
    longint u, u2, u3, v, ax, ay, rx, ry;
    longint basis [7];
    longint px [7];
    longint py [7];
    longint up [7];
    longint vp [7];
    longint binom6 [7] = '{1, 6, 15, 20, 15, 6, 1};
    longint binom3 [7] = '{1, 3, 3, 1, 0, 0, 0};
    int deg, terms, sh;
    bit sat;
    curve_point_t res;
    sat = 1'b0;
    sh = 16;
    terms = 4;
    ax = 0;
    ay = 0;
    u = it.param_u;
    if (u > 65536) u = 65536;
    u2 = mul_q16(u, u);
    u3 = mul_q16(u2, u);
    for (int k = 0; k < 7; k++) begin
      px[k] = ctrl_x[k];
      py[k] = ctrl_y[k];
      basis[k] = 0;
    end
    case (model_mode)
      pce_pkg::MODE_HERMITE: begin
        basis[0] = 2 * u3 - 3 * u2 + 65536;
        basis[1] = -2 * u3 + 3 * u2;
        basis[2] = u3 - 2 * u2 + u;
        basis[3] = u3 - u2;
      end
      pce_pkg::MODE_INTERP: begin
        sh = 17;
        basis[0] = -9 * u3 + 18 * u2 - 11 * u + 2 * 65536;
        basis[1] = 27 * u3 - 45 * u2 + 18 * u;
        basis[2] = -27 * u3 + 36 * u2 - 9 * u;
        basis[3] = 9 * u3 - 9 * u2 + 2 * u;
      end
      default: begin
        deg = (model_mode == pce_pkg::MODE_BEZ6) ? 6 : 3;
        terms = deg + 1;
        v = 65536 - u;
        up[0] = 65536;
        vp[0] = 65536;
        for (int k = 1; k <= deg; k++) begin
          up[k] = mul_q16(up[k - 1], u);
          vp[k] = mul_q16(vp[k - 1], v);
        end
        for (int k = 0; k <= deg; k++) begin
          basis[k] = ((deg == 6 ? binom6[k] : binom3[k]) * up[k] * vp[deg - k]
                      + 32768) >>> 16;
        end
        // Second joined segment uses the C1 derived point at full width.
        if (model_mode == pce_pkg::MODE_BEZ3X2 && it.segment) begin
          px[0] = ctrl_x[3];
          py[0] = ctrl_y[3];
          px[1] = 2 * ctrl_x[3] - ctrl_x[2];
          py[1] = 2 * ctrl_y[3] - ctrl_y[2];
          px[2] = ctrl_x[4];
          py[2] = ctrl_y[4];
          px[3] = ctrl_x[5];
          py[3] = ctrl_y[5];
        end
      end
    endcase
    for (int k = 0; k < terms; k++) begin
      ax += basis[k] * px[k];
      ay += basis[k] * py[k];
    end
    rx = clamp_coord(round_q(ax, sh), sat);
    ry = clamp_coord(round_q(ay, sh), sat);
    res.curve_x = rx[15:0];
    res.curve_y = ry[15:0];
    res.saturated = sat;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Driver: offers queued items with random gaps, changes at the falling edge.
  int gap_left;
  initial gap_left = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (in_chan.valid && !in_accepted) begin
      // Hold the offered item until it is taken.
    end else begin
      if (in_chan.valid) void'(pending_items.pop_front());
      if (gap_left > 0) begin
        gap_left--;
        in_chan.valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        curve_item_t it;
        it = pending_items[0];
        in_chan.valid       <= 1'b1;
        in_chan.operation   <= it.operation;
        in_chan.point_index <= it.point_index;
        in_chan.coord_x     <= it.coord_x;
        in_chan.coord_y     <= it.coord_y;
        in_chan.param_u     <= it.param_u;
        in_chan.segment     <= it.segment;
        gap_left = ($urandom_range(0, 9) < 6) ? 0 :
                   ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(10, 60);
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // Sender side bookkeeping: predictor update at each accepted item.
  always @(posedge clk) begin
    in_accepted = rst_n && in_chan.valid && in_chan.ready;
    if (in_accepted) begin
      if (in_chan.operation == pce_pkg::OP_LOAD) begin
        if (in_chan.point_index < NUM_POINTS) begin
          ctrl_x[in_chan.point_index] = longint'(in_chan.coord_x);
          ctrl_y[in_chan.point_index] = longint'(in_chan.coord_y);
        end
      end else begin
        curve_item_t it;
        it = {in_chan.operation, in_chan.point_index, in_chan.coord_x, in_chan.coord_y,
              in_chan.param_u, in_chan.segment};
        expected_points.push_back(predict_point(it));
        mode_evals[model_mode]++;
      end
    end
  end

  // Receiver ready: random stalls, plus a forced long hold-off.
  int stall_left;
  initial stall_left = 0;
  always @(negedge clk) begin
    if (!rst_n || hold_off) begin
      out_chan.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= 1'b1;
      if ($urandom_range(0, 9) < 2)
        stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 5) : $urandom_range(20, 80);
    end
  end

  // Monitor: compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      results_seen++;
      if (expected_points.size() == 0) begin
        report_mismatch("unexpected result", out_chan.curve_x, 0);
      end else begin
        curve_point_t want;
        want = expected_points.pop_front();
        if (want.saturated) sat_seen++;
        if (out_chan.curve_x !== want.curve_x)
          report_mismatch("curve_x", $signed(out_chan.curve_x), $signed(want.curve_x));
        if (out_chan.curve_y !== want.curve_y)
          report_mismatch("curve_y", $signed(out_chan.curve_y), $signed(want.curve_y));
        if (out_chan.saturated !== want.saturated)
          report_mismatch("saturated", out_chan.saturated, want.saturated);
      end
    end
  end

  function automatic curve_item_t load_item(int idx, int x, int y);
    curve_item_t it;
    it = '0;
    it.operation = pce_pkg::OP_LOAD;
    it.point_index = idx[2:0];
    it.coord_x = x[15:0];
    it.coord_y = y[15:0];
    it.param_u = 17'($urandom());
    it.segment = 1'($urandom());
    return it;
  endfunction

  function automatic curve_item_t eval_item(int u, bit seg);
    curve_item_t it;
    it = '0;
    it.operation = pce_pkg::OP_EVAL;
    it.point_index = 3'($urandom());
    it.coord_x = 16'($urandom());
    it.coord_y = 16'($urandom());
    it.param_u = u[16:0];
    it.segment = seg;
    return it;
  endfunction

  // Random coordinate: mostly moderate, sometimes full range or extremes.
  function automatic int rand_coord();
    case ($urandom_range(0, 9))
      0: return ($urandom_range(0, 1) != 0) ? 32767 : -32768;
      1, 2, 3: return int'($signed(16'($urandom())));
      default: return $urandom_range(0, 16383) - 8192;
    endcase
  endfunction

  function automatic int rand_param();
    case ($urandom_range(0, 9))
      0: return $urandom_range(65536, 131071);
      1: return ($urandom_range(0, 1) != 0) ? 0 : 65536;
      default: return $urandom_range(0, 65536);
    endcase
  endfunction

  // Waits until every queued item went out and every result came back.
  task automatic drain();
    while (pending_items.size() > 0 || in_chan.valid || expected_points.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_mode(pce_pkg::mode_t m);
    @(negedge clk);
    cfg_chan.valid <= 1'b1;
    cfg_chan.curve_mode <= m;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    model_mode = m;
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
  endtask

  // Stimulus.
  initial begin
    pce_pkg::mode_t m;
    int phase_items;
    mismatch_count = 0;
    results_seen = 0;
    sat_seen = 0;
    hold_off = 1'b0;
    stim_done = 1'b0;
    model_mode = pce_pkg::MODE_HERMITE;
    for (int k = 0; k < NUM_POINTS; k++) begin
      ctrl_x[k] = 0;
      ctrl_y[k] = 0;
    end
    for (int k = 0; k < 4; k++) mode_evals[k] = 0;
    in_chan.valid = 1'b0;
    in_chan.operation = pce_pkg::OP_LOAD;
    in_chan.point_index = '0;
    in_chan.coord_x = '0;
    in_chan.coord_y = '0;
    in_chan.param_u = '0;
    in_chan.segment = 1'b0;
    out_chan.ready = 1'b0;
    cfg_chan.valid = 1'b0;
    cfg_chan.curve_mode = pce_pkg::MODE_HERMITE;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: evaluation from reset, extremes of points, out of range load,
    // parameter above one and the second segment of the joined curve.
    pending_items.push_back(eval_item(32768, 0));
    for (int k = 0; k < 7; k++)
      pending_items.push_back(load_item(k, (k % 2) ? 32767 : -32768, (k % 2) ? -32768 : 32767));
    pending_items.push_back(load_item(7, 1234, -1234));
    pending_items.push_back(eval_item(0, 1));
    pending_items.push_back(eval_item(65536, 0));
    pending_items.push_back(eval_item(131071, 1));
    pending_items.push_back(eval_item(21845, 0));
    drain();
    for (int mi = 1; mi < 4; mi++) begin
      write_mode(pce_pkg::mode_t'(mi));
      pending_items.push_back(eval_item(0, 0));
      pending_items.push_back(eval_item(43690, 1));
      pending_items.push_back(eval_item(65536, 1));
      pending_items.push_back(eval_item(100000, 0));
      drain();
    end

    // Long receiver hold-off while the sender keeps offering items.
    for (int k = 0; k < 8; k++) pending_items.push_back(eval_item(rand_param(), 1'($urandom())));
    hold_off = 1'b1;
    repeat (300) @(posedge clk);
    hold_off = 1'b0;
    drain();

    // Random phases: well-formed point sets and evaluations in random order, with noise loads.
    for (int ph = 0; ph < 10; ph++) begin
      m = pce_pkg::mode_t'((ph < 4) ? ph : $urandom_range(0, 3));
      write_mode(m);
      phase_items = 0;
      while (phase_items < RANDOM_ITEMS / 10) begin
        if ($urandom_range(0, 3) == 0) begin
          for (int k = 0; k < 7; k++)
            pending_items.push_back(load_item(k, rand_coord(), rand_coord()));
          phase_items += 7;
        end else if ($urandom_range(0, 9) == 0) begin
          pending_items.push_back(load_item($urandom_range(0, 7), rand_coord(), rand_coord()));
          phase_items++;
        end else begin
          pending_items.push_back(eval_item(rand_param(), 1'($urandom())));
          phase_items++;
        end
      end
      drain();
    end
    stim_done = 1'b1;

    $display("covered %0d results; evaluations per mode %0d %0d %0d %0d; %0d saturated",
             results_seen, mode_evals[0], mode_evals[1], mode_evals[2], mode_evals[3],
             sat_seen);
    if (mismatch_count == 0 && expected_points.size() == 0) begin
      $display("parametric_curve_evaluator_tb: PASS");
    end else begin
      $display("parametric_curve_evaluator_tb: FAIL");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20ms;
    $display("timeout with %0d results outstanding", expected_points.size());
    $display("parametric_curve_evaluator_tb: FAIL");
    $finish;
  end

endmodule
